### src/rle4bsd_pkg.sv
// Package for the RLE4 bitmap span decoder: decode phases, escape codes,
// span attribute struct and shared width constants. No dependencies.
`timescale 1ns / 1ps

package rle4bsd_pkg;

  // Default coordinate width and result queue depth
  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned QDEPTH_DEF     = 2;

  // Fixed field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NIB_W   = 4;
  localparam int unsigned XY_W    = 12;
  localparam int unsigned ROW_W   = 13;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CFG_A_W = 2;

  // Tallest bitmap handled; taller heights are clipped to this
  localparam logic [ROW_W-1:0] HEIGHT_MAX = 13'd4096;

  // Second byte of an escape
  localparam logic [BYTE_W-1:0] ESC_EOL   = 8'h00;
  localparam logic [BYTE_W-1:0] ESC_EOB   = 8'h01;
  localparam logic [BYTE_W-1:0] ESC_DELTA = 8'h02;

  // Configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    CFG_X_ORIGIN = 2'd0,
    CFG_Y_ORIGIN = 2'd1,
    CFG_HEIGHT   = 2'd2
  } cfg_idx_e;

  // Decoder phases
  typedef enum logic [2:0] {
    PH_FIN   = 3'd0,
    PH_CMD   = 3'd1,
    PH_COLOR = 3'd2,
    PH_ESC   = 3'd3,
    PH_DX    = 3'd4,
    PH_DY    = 3'd5,
    PH_ABS   = 3'd6
  } phase_e;

  // Span attributes carried with each queued result
  typedef struct packed {
    logic [BYTE_W-1:0] len;
    logic [NIB_W-1:0]  color_even;
    logic [NIB_W-1:0]  color_odd;
    logic              finished;
  } span_attr_t;

endpackage

### src/rle4bsd_queue.sv
// Short result queue between the decode front and the output back end.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module rle4bsd_queue #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### src/rle4bsd_front.sv
// Decode front: accepts stream bytes, tracks the RLE4 grammar and the
// cursor, and pushes spans and finish reports. Uses rle4bsd_pkg.
`timescale 1ns / 1ps

module rle4bsd_front #(
  parameter int unsigned COORD_BITS = rle4bsd_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [rle4bsd_pkg::BYTE_W-1:0]      data_byte_i,
  input  logic                                start_of_bitmap_i,
  input  logic [rle4bsd_pkg::CFG_W-1:0]       height_i,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output logic [COORD_BITS-1:0]               q_col_o,
  output logic [rle4bsd_pkg::ROW_W-1:0]       q_row_o,
  output rle4bsd_pkg::span_attr_t             q_attr_o
);

  import rle4bsd_pkg::*;

  phase_e                   phase_q, phase_d, ph_e;
  logic [BYTE_W-1:0]        run_q, run_d, run_e;
  logic [BYTE_W-1:0]        dx_q, dx_d, dx_e;
  logic [BYTE_W-1:0]        abs_q, abs_d, abs_e;
  logic                     pad_q, pad_d, pad_e;
  logic [COORD_BITS-1:0]    col_q, col_d, col_e;
  logic signed [ROW_W-1:0]  row_q, row_d, row_e;

  logic                     accept;
  logic [ROW_W-1:0]         height_clip;
  logic signed [ROW_W-1:0]  start_row;
  logic                     zero_start;
  logic signed [ROW_W-1:0]  row_eol, row_dy;
  logic [BYTE_W-1:0]        abs_take, abs_left;
  logic [BYTE_W:0]          abs_inc;
  logic                     emit;
  span_attr_t               attr;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  // Resolve the start flag into the state this byte sees
  assign height_clip = (height_i > HEIGHT_MAX) ? HEIGHT_MAX : height_i;
  assign start_row   = $signed(height_clip - 13'd1);
  assign zero_start  = start_of_bitmap_i & start_row[ROW_W-1];

  assign ph_e  = start_of_bitmap_i ? (zero_start ? PH_FIN : PH_CMD) : phase_q;
  assign run_e = start_of_bitmap_i ? '0 : run_q;
  assign dx_e  = start_of_bitmap_i ? '0 : dx_q;
  assign abs_e = start_of_bitmap_i ? '0 : abs_q;
  assign pad_e = start_of_bitmap_i ? 1'b0 : pad_q;
  assign col_e = start_of_bitmap_i ? '0 : col_q;
  assign row_e = start_of_bitmap_i ? start_row : row_q;

  // Cursor moves and absolute-run bookkeeping
  assign row_eol  = row_e - 13'sd1;
  assign row_dy   = row_e - $signed({{(ROW_W - BYTE_W){1'b0}}, data_byte_i});
  assign abs_take = (abs_e >= 8'd2) ? 8'd2 : 8'd1;
  assign abs_left = abs_e - abs_take;
  assign abs_inc  = {1'b0, data_byte_i} + 9'd1;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (ph_e)
        PH_FIN:   phase_d = PH_FIN;
        PH_CMD:   phase_d = (data_byte_i != '0) ? PH_COLOR : PH_ESC;
        PH_COLOR: phase_d = PH_CMD;
        PH_ESC: begin
          if (data_byte_i == ESC_EOL) begin
            phase_d = row_eol[ROW_W-1] ? PH_FIN : PH_CMD;
          end else if (data_byte_i == ESC_EOB) begin
            phase_d = PH_FIN;
          end else if (data_byte_i == ESC_DELTA) begin
            phase_d = PH_DX;
          end else begin
            phase_d = PH_ABS;
          end
        end
        PH_DX:    phase_d = PH_DY;
        PH_DY:    phase_d = row_dy[ROW_W-1] ? PH_FIN : PH_CMD;
        PH_ABS: begin
          if (abs_e == '0) begin
            phase_d = PH_CMD;
          end else if (abs_left == '0 && !pad_e) begin
            phase_d = PH_CMD;
          end else begin
            phase_d = PH_ABS;
          end
        end
        default:  phase_d = PH_FIN;
      endcase
    end
  end

  // Datapath registers and the pushed result
  always_comb begin
    run_d = run_q;
    dx_d  = dx_q;
    abs_d = abs_q;
    pad_d = pad_q;
    col_d = col_q;
    row_d = row_q;
    emit  = 1'b0;
    attr  = '0;
    if (accept) begin
      run_d = run_e;
      dx_d  = dx_e;
      abs_d = abs_e;
      pad_d = pad_e;
      col_d = col_e;
      row_d = row_e;
      if (zero_start) begin
        emit          = 1'b1;
        attr.finished = 1'b1;
      end
      unique case (ph_e)
        PH_FIN: ;
        PH_CMD: begin
          if (data_byte_i != '0) begin
            run_d = data_byte_i;
          end
        end
        PH_COLOR: begin
          emit            = 1'b1;
          attr.len        = run_e;
          attr.color_even = data_byte_i[BYTE_W-1 -: NIB_W];
          attr.color_odd  = data_byte_i[NIB_W-1:0];
          col_d           = col_e + COORD_BITS'(run_e);
        end
        PH_ESC: begin
          if (data_byte_i == ESC_EOL) begin
            col_d = '0;
            row_d = row_eol;
            if (row_eol[ROW_W-1]) begin
              emit          = 1'b1;
              attr.finished = 1'b1;
            end
          end else if (data_byte_i == ESC_EOB) begin
            emit          = 1'b1;
            attr.finished = 1'b1;
          end else if (data_byte_i != ESC_DELTA) begin
            abs_d = data_byte_i;
            pad_d = abs_inc[1];
          end
        end
        PH_DX: begin
          dx_d = data_byte_i;
        end
        PH_DY: begin
          col_d = col_e + COORD_BITS'(dx_e);
          row_d = row_dy;
          if (row_dy[ROW_W-1]) begin
            emit          = 1'b1;
            attr.finished = 1'b1;
          end
        end
        PH_ABS: begin
          if (abs_e == '0) begin
            // drop the pad byte
            pad_d = 1'b0;
          end else begin
            emit            = 1'b1;
            attr.len        = abs_take;
            attr.color_even = data_byte_i[BYTE_W-1 -: NIB_W];
            attr.color_odd  = (abs_take == 8'd2) ? data_byte_i[NIB_W-1:0] : '0;
            col_d           = col_e + COORD_BITS'(abs_take);
            abs_d           = abs_left;
          end
        end
        default: ;
      endcase
    end
  end

  assign q_push_o = emit;
  assign q_col_o  = col_e;
  assign q_row_o  = row_e;
  assign q_attr_o = attr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIN;
      run_q   <= '0;
      dx_q    <= '0;
      abs_q   <= '0;
      pad_q   <= 1'b0;
      col_q   <= '0;
      row_q   <= '1;
    end else begin
      phase_q <= phase_d;
      run_q   <= run_d;
      dx_q    <= dx_d;
      abs_q   <= abs_d;
      pad_q   <= pad_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

endmodule

### src/rle4bsd_back.sv
// Output back end: takes queued spans, adds the screen origin, wraps the
// coordinates and holds the result in the output register. Uses rle4bsd_pkg.
`timescale 1ns / 1ps

module rle4bsd_back #(
  parameter int unsigned COORD_BITS = rle4bsd_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  output logic                              q_pop_o,
  input  logic [COORD_BITS-1:0]             q_col_i,
  input  logic [rle4bsd_pkg::ROW_W-1:0]     q_row_i,
  input  rle4bsd_pkg::span_attr_t           q_attr_i,
  input  logic [rle4bsd_pkg::XY_W-1:0]      x_origin_i,
  input  logic [rle4bsd_pkg::XY_W-1:0]      y_origin_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rle4bsd_pkg::XY_W-1:0]      span_x_o,
  output logic [rle4bsd_pkg::XY_W-1:0]      span_y_o,
  output logic [rle4bsd_pkg::BYTE_W-1:0]    span_len_o,
  output logic [rle4bsd_pkg::NIB_W-1:0]     color_even_o,
  output logic [rle4bsd_pkg::NIB_W-1:0]     color_odd_o,
  output logic                              finished_o
);

  import rle4bsd_pkg::*;

  localparam int unsigned SUM_W = (COORD_BITS > ROW_W) ? COORD_BITS : ROW_W;
  localparam logic [SUM_W-1:0] COORD_MASK = SUM_W'((64'd1 << COORD_BITS) - 64'd1);

  logic              out_valid_q;
  logic [XY_W-1:0]   span_x_q, span_y_q;
  logic [BYTE_W-1:0] span_len_q;
  logic [NIB_W-1:0]  color_even_q, color_odd_q;
  logic              finished_q;

  logic              load;
  logic [SUM_W-1:0]  sum_x, sum_y;
  logic [XY_W-1:0]   span_x_d, span_y_d;

  // Add origin and wrap to the coordinate width
  assign sum_x    = SUM_W'(q_col_i) + SUM_W'(x_origin_i);
  assign sum_y    = SUM_W'(q_row_i) + SUM_W'(y_origin_i);
  assign span_x_d = XY_W'(sum_x & COORD_MASK);
  assign span_y_d = XY_W'(sum_y & COORD_MASK);

  // Refill the output register when it is empty or being taken
  assign load    = q_valid_i & (~out_valid_q | ~out_stall_i);
  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= q_valid_i;
    end
  end

  // Finish reports carry zero coordinates and colors
  always_ff @(posedge clk_i) begin
    if (load) begin
      span_x_q     <= q_attr_i.finished ? '0 : span_x_d;
      span_y_q     <= q_attr_i.finished ? '0 : span_y_d;
      span_len_q   <= q_attr_i.len;
      color_even_q <= q_attr_i.color_even;
      color_odd_q  <= q_attr_i.color_odd;
      finished_q   <= q_attr_i.finished;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign span_x_o     = span_x_q;
  assign span_y_o     = span_y_q;
  assign span_len_o   = span_len_q;
  assign color_even_o = color_even_q;
  assign color_odd_o  = color_odd_q;
  assign finished_o   = finished_q;

endmodule

### src/rle4_bitmap_span_decoder.sv
// Top level of the RLE4 bitmap span decoder: configuration registers, decode
// front, result queue and output back end. Uses rle4bsd_pkg and submodules.
// Throughput: one byte per cycle; the input stalls only while the queue holds
// QDEPTH results behind a stalled output. The queue takes a span at the edge that
// accepts its last byte; the output register loads it once empty or being taken.
// Reset: asynchronous, clears origins and height and leaves the decoder
// finished, ignoring bytes until one arrives with the start flag set.
`timescale 1ns / 1ps

module rle4_bitmap_span_decoder #(
  parameter int unsigned COORD_BITS = rle4bsd_pkg::COORD_BITS_DEF,
  parameter int unsigned QDEPTH     = rle4bsd_pkg::QDEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rle4bsd_pkg::CFG_A_W-1:0]   cfg_idx_i,
  input  logic [rle4bsd_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rle4bsd_pkg::BYTE_W-1:0]    data_byte_i,
  input  logic                              start_of_bitmap_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rle4bsd_pkg::XY_W-1:0]      span_x_o,
  output logic [rle4bsd_pkg::XY_W-1:0]      span_y_o,
  output logic [rle4bsd_pkg::BYTE_W-1:0]    span_len_o,
  output logic [rle4bsd_pkg::NIB_W-1:0]     color_even_o,
  output logic [rle4bsd_pkg::NIB_W-1:0]     color_odd_o,
  output logic                              finished_o
);

  import rle4bsd_pkg::*;

  localparam int unsigned ATTR_W = $bits(span_attr_t);
  localparam int unsigned QW     = COORD_BITS + ROW_W + ATTR_W;

  logic [XY_W-1:0]       x_origin_q, y_origin_q;
  logic [CFG_W-1:0]      height_q;

  logic                  q_push, q_full, q_pop, q_valid;
  logic [COORD_BITS-1:0] f_col;
  logic [ROW_W-1:0]      f_row;
  span_attr_t            f_attr;
  logic [QW-1:0]         q_wdata, q_rdata;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q <= '0;
      y_origin_q <= '0;
      height_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_X_ORIGIN: x_origin_q <= cfg_wdata_i[XY_W-1:0];
        CFG_Y_ORIGIN: y_origin_q <= cfg_wdata_i[XY_W-1:0];
        CFG_HEIGHT:   height_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rle4bsd_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .start_of_bitmap_i(start_of_bitmap_i),
    .height_i         (height_q),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_col_o          (f_col),
    .q_row_o          (f_row),
    .q_attr_o         (f_attr)
  );

  assign q_wdata = {f_col, f_row, f_attr};

  rle4bsd_queue #(
    .WIDTH(QW),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_wdata),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_rdata)
  );

  rle4bsd_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_col_i     (q_rdata[QW-1 -: COORD_BITS]),
    .q_row_i     (q_rdata[ATTR_W +: ROW_W]),
    .q_attr_i    (span_attr_t'(q_rdata[ATTR_W-1:0])),
    .x_origin_i  (x_origin_q),
    .y_origin_i  (y_origin_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .span_x_o    (span_x_o),
    .span_y_o    (span_y_o),
    .span_len_o  (span_len_o),
    .color_even_o(color_even_o),
    .color_odd_o (color_odd_o),
    .finished_o  (finished_o)
  );

endmodule

### src/rle4bsd_checker.sv
// Port-level checks for the RLE4 bitmap span decoder, bound to its top level.
// Uses rle4bsd_pkg widths.
`timescale 1ns / 1ps

module rle4bsd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [rle4bsd_pkg::XY_W-1:0]    span_x_o,
  input logic [rle4bsd_pkg::XY_W-1:0]    span_y_o,
  input logic [rle4bsd_pkg::BYTE_W-1:0]  span_len_o,
  input logic [rle4bsd_pkg::NIB_W-1:0]   color_even_o,
  input logic [rle4bsd_pkg::NIB_W-1:0]   color_odd_o,
  input logic                            finished_o
);

  // Finish reports carry no span
  a_finish_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> span_x_o == '0 && span_y_o == '0 &&
      span_len_o == '0 && color_even_o == '0 && color_odd_o == '0)
    else $error("finish report with nonzero span fields");

  // Every real span has pixels
  a_span_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !finished_o |-> span_len_o != '0)
    else $error("span of zero length");

  // Hold a stalled result
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(span_x_o) && $stable(span_y_o) &&
      $stable(span_len_o) && $stable(color_even_o) && $stable(color_odd_o) &&
      $stable(finished_o))
    else $error("result changed under stall");

endmodule

bind rle4_bitmap_span_decoder rle4bsd_checker u_rle4bsd_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for rle4_bitmap_span_decoder: feeds coded RLE4 streams,
// predicts every span and finish report in a scoreboard class and checks them.
// Depends on rle4bsd_pkg and the decoder top level only.
`timescale 1ns / 1ps

module tb_top;
  import rle4bsd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  // One expected or observed span
  typedef struct packed {
    logic [XY_W-1:0]   x;
    logic [XY_W-1:0]   y;
    logic [BYTE_W-1:0] len;
    logic [NIB_W-1:0]  c_even;
    logic [NIB_W-1:0]  c_odd;
    logic              fin;
  } span_t;

  // Span scoreboard: tracks decoder state, queues the spans it must produce
  class span_scoreboard;
    span_t             span_q[$];
    int                errors;
    logic [XY_W-1:0]   x_org;
    logic [XY_W-1:0]   y_org;
    logic [ROW_W-1:0]  height;
    phase_e            phase;
    logic [BYTE_W-1:0] run_len;
    logic [BYTE_W-1:0] dx;
    logic [BYTE_W-1:0] abs_left;
    bit                pad;
    logic [XY_W-1:0]   col;
    int                row;

    function new();
      errors   = 0;
      x_org    = '0;
      y_org    = '0;
      height   = '0;
      phase    = PH_FIN;
      run_len  = '0;
      dx       = '0;
      abs_left = '0;
      pad      = 1'b0;
      col      = '0;
      row      = -1;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_X_ORIGIN: x_org = v[XY_W-1:0];
        CFG_Y_ORIGIN: y_org = v[XY_W-1:0];
        CFG_HEIGHT:   height = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return span_q.size();
    endfunction

    function void add_span(logic [BYTE_W-1:0] len, logic [NIB_W-1:0] ce, logic [NIB_W-1:0] co);
      span_t s;
      logic [XY_W-1:0] r;
      r = row[XY_W-1:0];
      s.x = col + x_org;
      s.y = r + y_org;
      s.len = len;
      s.c_even = ce;
      s.c_odd = co;
      s.fin = 1'b0;
      span_q.push_back(s);
    endfunction

    // Queue the all-zero finish report and park the decoder
    function void add_finish();
      span_t s;
      s = '0;
      s.fin = 1'b1;
      span_q.push_back(s);
      phase = PH_FIN;
    endfunction

    // Advance the decoder by one accepted word
    function void decode_byte(logic [BYTE_W-1:0] b, bit start);
      int h;
      int nbytes;
      logic [BYTE_W-1:0] n;
      if (start) begin
        h = (height > HEIGHT_MAX) ? int'(HEIGHT_MAX) : int'(height);
        col = '0;
        run_len = '0;
        dx = '0;
        abs_left = '0;
        pad = 1'b0;
        row = h - 1;
        if (row < 0) begin
          add_finish();
          return;
        end
        phase = PH_CMD;
      end
      case (phase)
        PH_CMD: begin
          if (b != 0) begin
            run_len = b;
            phase = PH_COLOR;
          end else begin
            phase = PH_ESC;
          end
        end
        PH_COLOR: begin
          add_span(run_len, b[7:4], b[3:0]);
          col = col + run_len;
          phase = PH_CMD;
        end
        PH_ESC: begin
          if (b == ESC_EOL) begin
            col = '0;
            row = row - 1;
            if (row < 0) add_finish();
            else phase = PH_CMD;
          end else if (b == ESC_EOB) begin
            add_finish();
          end else if (b == ESC_DELTA) begin
            phase = PH_DX;
          end else begin
            // pad follows when the run uses an odd number of data bytes
            abs_left = b;
            nbytes = (int'(b) + 1) / 2;
            pad = nbytes[0];
            phase = PH_ABS;
          end
        end
        PH_DX: begin
          dx = b;
          phase = PH_DY;
        end
        PH_DY: begin
          col = col + dx;
          row = row - int'(b);
          if (row < 0) add_finish();
          else phase = PH_CMD;
        end
        PH_ABS: begin
          if (abs_left == 0) begin
            pad = 1'b0;
            phase = PH_CMD;
          end else begin
            n = (abs_left >= 2) ? 8'd2 : 8'd1;
            add_span(n, b[7:4], (n == 2) ? b[3:0] : 4'd0);
            col = col + n;
            abs_left = abs_left - n;
            if (abs_left == 0 && !pad) phase = PH_CMD;
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare an accepted span with the oldest expectation
    function void check_span(span_t got);
      span_t want;
      if (span_q.size() == 0) begin
        $display("%0t ns: span with nothing expected: x=%0d y=%0d len=%0d fin=%0d",
                 $time, got.x, got.y, got.len, got.fin);
        errors++;
        return;
      end
      want = span_q.pop_front();
      compare_field("span_x", int'(want.x), int'(got.x));
      compare_field("span_y", int'(want.y), int'(got.y));
      compare_field("span_len", int'(want.len), int'(got.len));
      compare_field("color_even", int'(want.c_even), int'(got.c_even));
      compare_field("color_odd", int'(want.c_odd), int'(got.c_odd));
      compare_field("finished", int'(want.fin), int'(got.fin));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  cfg_idx_e          cfg_idx = CFG_X_ORIGIN;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              start_flag = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [XY_W-1:0]   span_x;
  logic [XY_W-1:0]   span_y;
  logic [BYTE_W-1:0] span_len;
  logic [NIB_W-1:0]  color_even;
  logic [NIB_W-1:0]  color_odd;
  logic              finished;

  span_scoreboard span_sb;
  bit  in_idle_on = 1'b1;
  bit  out_idle_on = 1'b1;
  bit  idle_allowed = 1'b1;
  bit  start_next = 1'b0;
  int  bytes_sent = 0;
  int  phase_stop = 0;
  int  stall_left = 0;
  int  cycles = 0;

  rle4_bitmap_span_decoder DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .data_byte_i       (data_byte),
    .start_of_bitmap_i (start_flag),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .span_x_o          (span_x),
    .span_y_o          (span_y),
    .span_len_o        (span_len),
    .color_even_o      (color_even),
    .color_odd_o       (color_odd),
    .finished_o        (finished)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stall the output side in random bursts while output idling is on
  always @(posedge clk_i) begin
    if (!out_idle_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check every accepted output word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall)
      span_sb.check_span('{x: span_x, y: span_y, len: span_len, c_even: color_even,
                           c_odd: color_odd, fin: finished});
  end

  // Offer one word, hold it until accepted, then predict its result
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    bit s;
    s = start_next;
    start_next = 1'b0;
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    start_flag <= s;
    do @(posedge clk_i); while (in_stall);
    span_sb.decode_byte(b, s);
    bytes_sent++;
  endtask

  // Hold off the sender until every expected span is out, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (span_sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_W-1:0] x, input logic [CFG_W-1:0] y,
                           input logic [CFG_W-1:0] h);
    logic [CFG_W-1:0] vals [3];
    vals[0] = x;
    vals[1] = y;
    vals[2] = h;
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= cfg_idx_e'(i);
      cfg_wdata <= vals[i];
      @(posedge clk_i);
      span_sb.set_reg(cfg_idx_e'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_run();
    int cnt;
    cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 16);
    send_byte(cnt[7:0]);
    send_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic send_abs();
    int n;
    int nbytes;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
    nbytes = (n + 1) / 2;
    send_byte(8'h00);
    send_byte(n[7:0]);
    repeat (nbytes) send_byte(BYTE_W'($urandom_range(0, 255)));
    if (nbytes % 2 == 1) send_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic send_delta();
    send_byte(8'h00);
    send_byte(ESC_DELTA);
    send_byte(BYTE_W'($urandom_range(0, 255)));
    send_byte(BYTE_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 1)));
  endtask

  // Random word, sometimes with the start flag, to break sequences
  task automatic send_noise();
    start_next = start_next | ($urandom_range(0, 7) == 0);
    send_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  // One coded bitmap: start flag on the first word, random ops, usually an end marker
  task automatic send_bitmap();
    int pick;
    in_idle_on = idle_allowed && ($urandom_range(0, 3) != 0);
    out_idle_on = idle_allowed && ($urandom_range(0, 3) != 0);
    start_next = 1'b1;
    repeat ($urandom_range(2, 20)) begin
      if (bytes_sent >= phase_stop) break;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_run();
      end else if (pick < 60) begin
        send_abs();
      end else if (pick < 78) begin
        send_byte(8'h00);
        send_byte(ESC_EOL);
      end else if (pick < 94) begin
        send_delta();
      end else begin
        send_noise();
      end
    end
    if ($urandom_range(0, 9) < 7) begin
      send_byte(8'h00);
      send_byte(ESC_EOB);
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_noise();
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] x, input logic [CFG_W-1:0] y,
                           input logic [CFG_W-1:0] h, input int words);
    int stop_at;
    drain();
    write_cfg(x, y, h);
    stop_at = bytes_sent + words;
    phase_stop = stop_at;
    while (bytes_sent < stop_at) begin
      send_bitmap();
      if (idle_allowed && $urandom_range(0, 5) == 0) drain();
    end
  endtask

  // Directed stream: ignored word while finished, then run, end of line, delta,
  // even and odd absolute runs (with pad), longest run, end of bitmap
  logic [BYTE_W-1:0] intro [23] = '{
    8'h05,
    8'h03, 8'hAB,
    8'h00, 8'h00,
    8'h00, 8'h02, 8'hFF, 8'h01,
    8'h00, 8'h03, 8'h12, 8'h30,
    8'h00, 8'h05, 8'hFF, 8'h00, 8'h80, 8'h77,
    8'hFF, 8'h5A,
    8'h00, 8'h01
  };

  initial begin
    span_sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_cfg(13'd0, 13'd0, 13'd4);
    foreach (intro[i]) begin
      start_next = (i == 1);
      send_byte(intro[i]);
    end

    // zero height, extremes with column wrap, oversized heights, single row, small heights
    run_phase(13'd0, 13'd0, 13'd0, 12);
    run_phase(13'd4095, 13'd4095, 13'd4096, 150);
    run_phase(CFG_W'($urandom_range(0, 8191)), CFG_W'($urandom_range(0, 8191)),
              13'd8191, 80);
    run_phase(CFG_W'($urandom_range(0, 4095)), CFG_W'($urandom_range(0, 4095)),
              CFG_W'($urandom_range(4097, 8190)), 70);
    run_phase(CFG_W'($urandom_range(0, 4095)), CFG_W'($urandom_range(0, 4095)),
              13'd1, 100);
    run_phase(CFG_W'($urandom_range(0, 4095)), CFG_W'($urandom_range(0, 4095)),
              CFG_W'($urandom_range(2, 16)), 150);

    // closing stretch at full rate on both sides
    idle_allowed = 1'b0;
    run_phase(CFG_W'($urandom_range(0, 4095)), CFG_W'($urandom_range(0, 4095)),
              CFG_W'($urandom_range(2, 8)), 150);
    drain();

    if (span_sb.errors == 0 && span_sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (span_sb.pending() != 0)
        $display("%0t ns: %0d expected spans never arrived", $time, span_sb.pending());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
src/rle4bsd_pkg.sv
src/rle4bsd_queue.sv
src/rle4bsd_front.sv
src/rle4bsd_back.sv
src/rle4_bitmap_span_decoder.sv
src/rle4bsd_checker.sv
tb/tb_top.sv
